>>> sv/smlt_pkg.sv
package smlt_pkg;

   localparam int WordWidth  = 32;
   localparam int SpeedWidth = 31;
   localparam int TimeWidth  = 16;
   localparam int StepWidth  = SpeedWidth + TimeWidth;
   localparam int SumWidth   = 64;
   localparam int LenWidth   = 32;
   localparam int LenqWidth  = StepWidth + 1;
   localparam int NumWidth   = WordWidth + StepWidth;
   localparam int QuoWidth   = 32;
   localparam int RootStages = 32;
   localparam int DivStages  = QuoWidth;
   localparam int Axes       = 3;

   localparam logic [SpeedWidth-1:0] SpeedReset = 31'd65536;
   localparam logic                  AddrSpeed  = 1'b0;

   typedef struct packed {
      logic [Axes-1:0][WordWidth-1:0] cur;
      logic [Axes-1:0][WordWidth-1:0] goal;
      logic [Axes-1:0]                neg;
      logic [Axes-1:0][WordWidth-1:0] mag;
      logic [StepWidth-1:0]           step;
   } carry_a_type;

   typedef struct packed {
      logic [Axes-1:0][WordWidth-1:0] cur;
      logic [Axes-1:0][WordWidth-1:0] goal;
      logic [Axes-1:0]                neg;
      logic [Axes-1:0][WordWidth-1:0] mag;
      logic                           moving;
   } carry_b_type;

endpackage

>>> sv/smlt_isqrt.sv
module smlt_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [smlt_pkg::SumWidth-1:0] num,
   output logic [smlt_pkg::LenWidth-1:0] root
);
   import smlt_pkg::*;

   logic [SumWidth-1:0] n_ff [RootStages];
   logic [SumWidth-1:0] r_ff [RootStages];

   for (genvar k = 0; k < RootStages; k++) begin : g_stage
      logic [SumWidth-1:0] n_src, r_src, n_in, r_in, bitv, trial;
      always_comb begin
         n_src = (k == 0) ? num : n_ff[(k == 0) ? 0 : k - 1];
         r_src = (k == 0) ? '0  : r_ff[(k == 0) ? 0 : k - 1];
         bitv  = SumWidth'(1) << (2 * (RootStages - 1 - k));
         trial = r_src + bitv;
         if (n_src >= trial) begin
            n_in = n_src - trial;
            r_in = (r_src >> 1) + bitv;
         end else begin
            n_in = n_src;
            r_in = r_src >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root = r_ff[RootStages-1][LenWidth-1:0];

endmodule

>>> sv/smlt_div.sv
module smlt_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [smlt_pkg::NumWidth-1:0]  num,
   input  logic [smlt_pkg::LenqWidth-1:0] den,
   output logic [smlt_pkg::QuoWidth-1:0]  quo
);
   import smlt_pkg::*;

   logic [LenqWidth-1:0] r_ff [DivStages];
   logic [LenqWidth-1:0] d_ff [DivStages];
   logic [QuoWidth-1:0]  lo_ff [DivStages];
   logic [QuoWidth-1:0]  q_ff [DivStages];

   for (genvar j = 0; j < DivStages; j++) begin : g_stage
      logic [LenqWidth-1:0] r_src, d_src, r_in;
      logic [QuoWidth-1:0]  lo_src, q_src;
      logic [LenqWidth:0]   t;
      logic                 ge;
      always_comb begin
         if (j == 0) begin
            r_src  = LenqWidth'(num[NumWidth-1:QuoWidth]);
            d_src  = den;
            lo_src = num[QuoWidth-1:0];
            q_src  = '0;
         end else begin
            r_src  = r_ff[(j == 0) ? 0 : j - 1];
            d_src  = d_ff[(j == 0) ? 0 : j - 1];
            lo_src = lo_ff[(j == 0) ? 0 : j - 1];
            q_src  = q_ff[(j == 0) ? 0 : j - 1];
         end
         t    = {r_src, lo_src[QuoWidth-1]};
         ge   = t >= {1'b0, d_src};
         r_in = ge ? LenqWidth'(t - {1'b0, d_src}) : t[LenqWidth-1:0];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]  <= r_in;
            d_ff[j]  <= d_src;
            lo_ff[j] <= {lo_src[QuoWidth-2:0], 1'b0};
            q_ff[j]  <= {q_src[QuoWidth-2:0], ge};
         end
      end
   end

   assign quo = q_ff[DivStages-1];

endmodule

>>> sv/speed_limited_move_toward_unit.sv
// Moves a 3D Q16.16 position toward a goal by at most max_speed * time_step per beat.
// Fully pipelined: one beat accepted per cycle while not stalled, passing through the 32-stage
// square root and the 32-stage divider (one per axis). rsp_stall with a result waiting
// freezes the whole pipeline and raises req_stall. max_speed lies at byte address 0.
module speed_limited_move_toward_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_cur_x,
   input  logic [31:0] req_cur_y,
   input  logic [31:0] req_cur_z,
   input  logic [31:0] req_goal_x,
   input  logic [31:0] req_goal_y,
   input  logic [31:0] req_goal_z,
   input  logic [15:0] req_time_step,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic        rsp_arrived,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import smlt_pkg::*;

   localparam int VLen   = 3 + RootStages + 2 + DivStages + 1;
   localparam int SqOut  = 2 + RootStages;
   localparam int DivOut = SqOut + 2 + DivStages;

   logic                  adv;
   logic [VLen-1:0]       v_ff, v_in;
   logic [SpeedWidth-1:0] speed_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == AddrSpeed) ? {1'b0, speed_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SpeedReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == AddrSpeed) begin
         speed_ff <= csr_pwdata[SpeedWidth-1:0];
      end
   end

   assign adv       = !(v_ff[VLen-1] && rsp_stall);
   assign req_stall = !adv;
   assign v_in      = {v_ff[VLen-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // stage 1: saturated differences and step
   logic [Axes-1:0][WordWidth-1:0] cur_w, goal_w;
   carry_a_type a_in;
   carry_a_type a_ff [SqOut+1];

   assign cur_w  = {req_cur_z, req_cur_y, req_cur_x};
   assign goal_w = {req_goal_z, req_goal_y, req_goal_x};

   always_comb begin
      logic signed [WordWidth:0] d;
      logic [WordWidth-1:0]      ds;
      a_in.cur  = cur_w;
      a_in.goal = goal_w;
      a_in.step = StepWidth'(speed_ff) * StepWidth'(req_time_step);
      for (int i = 0; i < Axes; i++) begin
         d = $signed({goal_w[i][WordWidth-1], goal_w[i]})
           - $signed({cur_w[i][WordWidth-1], cur_w[i]});
         if (d[WordWidth] != d[WordWidth-1])
            ds = d[WordWidth] ? {1'b1, {(WordWidth-1){1'b0}}} : {1'b0, {(WordWidth-1){1'b1}}};
         else
            ds = d[WordWidth-1:0];
         a_in.neg[i] = ds[WordWidth-1];
         a_in.mag[i] = ds[WordWidth-1] ? WordWidth'(-ds) : ds;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0] <= a_in;
         for (int s = 1; s <= SqOut; s++) a_ff[s] <= a_ff[s-1];
      end
   end

   // stages 2 and 3: squares and their sum
   logic [Axes-1:0][SumWidth-1:0] sq_ff;
   logic [SumWidth-1:0]           sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Axes; i++) sq_ff[i] <= SumWidth'(a_ff[0].mag[i] * a_ff[0].mag[i]);
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   logic [LenWidth-1:0] len;

   smlt_isqrt u_isqrt (
      .clock (clock),
      .en    (adv),
      .num   (sum_ff),
      .root  (len)
   );

   // move test and split products
   carry_a_type                        a_top;
   logic [LenqWidth-1:0]               lenq_in, lenq_ff, lenq2_ff;
   logic [Axes-1:0][WordWidth+23:0]    pa_ff;
   logic [Axes-1:0][WordWidth+22:0]    pb_ff;
   logic [Axes-1:0][NumWidth-1:0]      num_ff;
   carry_b_type                        b_ff [DivStages+2];

   assign a_top   = a_ff[SqOut];
   assign lenq_in = {len, 16'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Axes; i++) begin
            pa_ff[i]  <= (WordWidth+24)'(a_top.mag[i] * a_top.step[23:0]);
            pb_ff[i]  <= (WordWidth+23)'(a_top.mag[i] * a_top.step[StepWidth-1:24]);
            num_ff[i] <= NumWidth'(pa_ff[i]) + (NumWidth'(pb_ff[i]) << 24);
         end
         lenq_ff        <= lenq_in;
         lenq2_ff       <= lenq_ff;
         b_ff[0].cur    <= a_top.cur;
         b_ff[0].goal   <= a_top.goal;
         b_ff[0].neg    <= a_top.neg;
         b_ff[0].mag    <= a_top.mag;
         b_ff[0].moving <= LenqWidth'(a_top.step) < lenq_in;
         for (int s = 1; s < DivStages + 2; s++) b_ff[s] <= b_ff[s-1];
      end
   end

   logic [Axes-1:0][QuoWidth-1:0] quo;

   for (genvar i = 0; i < Axes; i++) begin : g_div
      smlt_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (num_ff[i]),
         .den   (lenq2_ff),
         .quo   (quo[i])
      );
   end

   // output stage
   carry_b_type                    b_top;
   logic [Axes-1:0][WordWidth-1:0] res_in, res_ff;
   logic                           arr_ff;

   assign b_top = b_ff[DivStages+1];

   always_comb begin
      logic signed [WordWidth+1:0] delta, sum;
      for (int i = 0; i < Axes; i++) begin
         delta = b_top.neg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
         sum   = $signed({{2{b_top.cur[i][WordWidth-1]}}, b_top.cur[i]}) + delta;
         if (!b_top.moving)
            res_in[i] = b_top.goal[i];
         else if (sum > $signed({3'b000, {(WordWidth-1){1'b1}}}))
            res_in[i] = {1'b0, {(WordWidth-1){1'b1}}};
         else if (sum < -$signed({3'b001, {(WordWidth-1){1'b0}}}))
            res_in[i] = {1'b1, {(WordWidth-1){1'b0}}};
         else
            res_in[i] = sum[WordWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         arr_ff <= !b_top.moving;
      end
   end

   assign rsp_valid   = v_ff[VLen-1];
   assign rsp_out_x   = res_ff[0];
   assign rsp_out_y   = res_ff[1];
   assign rsp_out_z   = res_ff[2];
   assign rsp_arrived = arr_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("pipeline not empty after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("valid line moved during stall");
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[DivOut] && b_top.moving |-> quo[0] <= b_top.mag[0])
      else $error("quotient exceeds difference");
`endif

endmodule
